FILE: sv/link_health_supervisor_core_macros.svh
// Assertion helpers for the link health supervisor.
// Each macro checks on the rising edge of clk and is off while rst_n is low.
`ifndef LINK_HEALTH_SUPERVISOR_CORE_MACROS_SVH
`define LINK_HEALTH_SUPERVISOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LHSC_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LHSC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lhs_pkg.sv
`default_nettype none

package lhs_pkg;

    typedef enum logic [5:0] {
        MODE_IDLE      = 6'b000001,
        MODE_AWAIT     = 6'b000010,
        MODE_CONFIRM   = 6'b000100,
        MODE_CONNECTED = 6'b001000,
        MODE_RECONNECT = 6'b010000,
        MODE_FAILED    = 6'b100000
    } mode_t;

    localparam logic [2:0] LINK_IDLE      = 3'd0;
    localparam logic [2:0] LINK_AWAIT     = 3'd1;
    localparam logic [2:0] LINK_CONFIRM   = 3'd2;
    localparam logic [2:0] LINK_CONNECTED = 3'd3;
    localparam logic [2:0] LINK_RECONNECT = 3'd4;
    localparam logic [2:0] LINK_FAILED    = 3'd5;

    localparam logic [2:0] CFG_INITIAL_WAIT      = 3'd0;
    localparam logic [2:0] CFG_LOST_WAIT         = 3'd1;
    localparam logic [2:0] CFG_RECONNECT_WAIT    = 3'd2;
    localparam logic [2:0] CFG_UPDATE_WAIT       = 3'd3;
    localparam logic [2:0] CFG_VALID_NEEDED      = 3'd4;
    localparam logic [2:0] CFG_MISSED_ALLOWED    = 3'd5;
    localparam logic [2:0] CFG_RECONNECT_ALLOWED = 3'd6;

    localparam logic [15:0] RST_INITIAL_WAIT      = 16'd20000;
    localparam logic [15:0] RST_LOST_WAIT         = 16'd500;
    localparam logic [15:0] RST_RECONNECT_WAIT    = 16'd10000;
    localparam logic [15:0] RST_UPDATE_WAIT       = 16'd30;
    localparam logic [7:0]  RST_VALID_NEEDED      = 8'd10;
    localparam logic [7:0]  RST_MISSED_ALLOWED    = 8'd5;
    localparam logic [7:0]  RST_RECONNECT_ALLOWED = 8'd3;

    typedef struct packed {
        logic [15:0] initial_wait_ms;
        logic [15:0] lost_wait_ms;
        logic [15:0] reconnect_wait_ms;
        logic [15:0] update_wait_ms;
        logic [7:0]  valid_needed;
        logic [7:0]  missed_allowed;
        logic [7:0]  reconnect_allowed;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] wait_timer;
        logic [7:0]  valid_count;
        logic [7:0]  missed_count;
        logic [7:0]  attempt_count;
    } state_t;

    function automatic logic [2:0] link_code(input mode_t m);
        logic [2:0] code;
        case (m)
            MODE_IDLE:      code = LINK_IDLE;
            MODE_AWAIT:     code = LINK_AWAIT;
            MODE_CONFIRM:   code = LINK_CONFIRM;
            MODE_CONNECTED: code = LINK_CONNECTED;
            MODE_RECONNECT: code = LINK_RECONNECT;
            default:        code = LINK_FAILED;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: sv/lhs_step.sv
`default_nettype none

module lhs_step (
    input  wire lhs_pkg::cfg_t   cfg,
    input  wire lhs_pkg::state_t state,
    input  wire logic            start_req,
    input  wire logic            status_update,
    input  wire logic            tick,
    output lhs_pkg::state_t      state_next
);

    logic [15:0]     timer_inc;
    logic [7:0]      valid_inc;
    logic [7:0]      missed_inc;
    logic [15:0]     limit;
    logic            expired;
    lhs_pkg::state_t reconn;

    always_comb
    begin
        timer_inc  = (state.wait_timer != 16'hFFFF) ? state.wait_timer + 16'd1
                                                    : state.wait_timer;
        valid_inc  = (state.valid_count != 8'hFF) ? state.valid_count + 8'd1
                                                  : state.valid_count;
        missed_inc = (state.missed_count != 8'hFF) ? state.missed_count + 8'd1
                                                   : state.missed_count;

        case (state.mode)
            lhs_pkg::MODE_AWAIT:     limit = cfg.initial_wait_ms;
            lhs_pkg::MODE_CONFIRM:   limit = cfg.update_wait_ms;
            lhs_pkg::MODE_CONNECTED: limit = cfg.lost_wait_ms;
            default:                 limit = cfg.reconnect_wait_ms;
        endcase
        expired = tick && (timer_inc >= limit);

        // Entry to reconnecting; fails at once when the attempts are used up.
        reconn              = state;
        reconn.wait_timer   = 16'd0;
        reconn.valid_count  = 8'd0;
        reconn.missed_count = 8'd0;
        if (state.attempt_count >= cfg.reconnect_allowed)
        begin
            reconn.mode = lhs_pkg::MODE_FAILED;
        end
        else
        begin
            reconn.mode          = lhs_pkg::MODE_RECONNECT;
            reconn.attempt_count = state.attempt_count + 8'd1;
        end

        state_next = state;
        case (state.mode)
            lhs_pkg::MODE_IDLE:
            begin
                if (start_req)
                begin
                    state_next.mode          = lhs_pkg::MODE_AWAIT;
                    state_next.wait_timer    = 16'd0;
                    state_next.valid_count   = 8'd0;
                    state_next.missed_count  = 8'd0;
                    state_next.attempt_count = 8'd0;
                end
            end
            lhs_pkg::MODE_AWAIT, lhs_pkg::MODE_RECONNECT:
            begin
                if (status_update)
                begin
                    state_next.mode         = lhs_pkg::MODE_CONFIRM;
                    state_next.wait_timer   = 16'd0;
                    state_next.valid_count  = 8'd0;
                    state_next.missed_count = 8'd0;
                end
                else if (expired)
                begin
                    state_next.mode       = lhs_pkg::MODE_FAILED;
                    state_next.wait_timer = 16'd0;
                end
                else if (tick)
                begin
                    state_next.wait_timer = timer_inc;
                end
            end
            lhs_pkg::MODE_CONFIRM:
            begin
                if (status_update)
                begin
                    state_next.wait_timer = 16'd0;
                    if (valid_inc >= cfg.valid_needed)
                    begin
                        state_next.mode         = lhs_pkg::MODE_CONNECTED;
                        state_next.valid_count  = 8'd0;
                        state_next.missed_count = 8'd0;
                    end
                    else
                    begin
                        state_next.valid_count = valid_inc;
                    end
                end
                else if (expired)
                begin
                    if (missed_inc >= cfg.missed_allowed)
                    begin
                        state_next = reconn;
                    end
                    else
                    begin
                        state_next.wait_timer   = 16'd0;
                        state_next.valid_count  = 8'd0;
                        state_next.missed_count = missed_inc;
                    end
                end
                else if (tick)
                begin
                    state_next.wait_timer = timer_inc;
                end
            end
            lhs_pkg::MODE_CONNECTED:
            begin
                if (status_update)
                begin
                    state_next.wait_timer = 16'd0;
                end
                else if (expired)
                begin
                    state_next = reconn;
                end
                else if (tick)
                begin
                    state_next.wait_timer = timer_inc;
                end
            end
            lhs_pkg::MODE_FAILED:
            begin
                state_next = state;
            end
            default:
            begin
                state_next.mode = lhs_pkg::MODE_FAILED;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/link_health_supervisor_core.sv
// Link health supervisor core.
// The input channel carries one word per event slot: start_req, status_update
// and tick, qualified by in_valid and held off by in_stall. The output channel
// returns one word per input word: link_state, connected and failed, qualified
// by out_valid and held off by out_stall.
// A taken word is held in the input register, and its result is registered in the
// result register when the output advances. One word is taken every cycle unless
// in_stall is high; the supervisor state update is a single compare-and-count step
// between the two registers.
// When the receiver stalls, the result register holds its word and the input
// register fills; in_stall rises only when both are full, so the input register
// still absorbs one more word after the stall begins only if it was empty.
// Reset clears both valid flags, returns the supervisor to idle with all
// counters at zero and loads the default timing and count registers.
// The configuration port writes one register per cycle with cfg_write high;
// the narrow count registers take the low byte of cfg_data.
`default_nettype none

`include "link_health_supervisor_core_macros.svh"

module link_health_supervisor_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        start_req,
    input  wire logic        status_update,
    input  wire logic        tick,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       link_state,
    output logic             connected,
    output logic             failed
);

    lhs_pkg::cfg_t   cfg_reg;
    lhs_pkg::cfg_t   cfg_next;
    lhs_pkg::state_t state_reg;
    lhs_pkg::state_t state_next;
    lhs_pkg::state_t step_result;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic s1_start_reg;
    logic s1_update_reg;
    logic s1_tick_reg;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [2:0] link_state_reg;
    logic       connected_reg;
    logic       failed_reg;

    logic advance;
    logic in_take;

    lhs_step u_step (
        .cfg           (cfg_reg),
        .state         (state_reg),
        .start_req     (s1_start_reg),
        .status_update (s1_update_reg),
        .tick          (s1_tick_reg),
        .state_next    (step_result)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                lhs_pkg::CFG_INITIAL_WAIT:      cfg_next.initial_wait_ms   = cfg_data;
                lhs_pkg::CFG_LOST_WAIT:         cfg_next.lost_wait_ms      = cfg_data;
                lhs_pkg::CFG_RECONNECT_WAIT:    cfg_next.reconnect_wait_ms = cfg_data;
                lhs_pkg::CFG_UPDATE_WAIT:       cfg_next.update_wait_ms    = cfg_data;
                lhs_pkg::CFG_VALID_NEEDED:      cfg_next.valid_needed      = cfg_data[7:0];
                lhs_pkg::CFG_MISSED_ALLOWED:    cfg_next.missed_allowed    = cfg_data[7:0];
                lhs_pkg::CFG_RECONNECT_ALLOWED: cfg_next.reconnect_allowed = cfg_data[7:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end

        state_next     = (advance && s1_valid_reg) ? step_result : state_reg;
        s1_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_wait_ms   <= lhs_pkg::RST_INITIAL_WAIT;
            cfg_reg.lost_wait_ms      <= lhs_pkg::RST_LOST_WAIT;
            cfg_reg.reconnect_wait_ms <= lhs_pkg::RST_RECONNECT_WAIT;
            cfg_reg.update_wait_ms    <= lhs_pkg::RST_UPDATE_WAIT;
            cfg_reg.valid_needed      <= lhs_pkg::RST_VALID_NEEDED;
            cfg_reg.missed_allowed    <= lhs_pkg::RST_MISSED_ALLOWED;
            cfg_reg.reconnect_allowed <= lhs_pkg::RST_RECONNECT_ALLOWED;
            state_reg.mode            <= lhs_pkg::MODE_IDLE;
            state_reg.wait_timer      <= 16'd0;
            state_reg.valid_count     <= 8'd0;
            state_reg.missed_count    <= 8'd0;
            state_reg.attempt_count   <= 8'd0;
            s1_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            state_reg     <= state_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_start_reg  <= start_req;
            s1_update_reg <= status_update;
            s1_tick_reg   <= tick;
        end
        if (advance && s1_valid_reg)
        begin
            link_state_reg <= lhs_pkg::link_code(step_result.mode);
            connected_reg  <= (step_result.mode == lhs_pkg::MODE_CONNECTED);
            failed_reg     <= (step_result.mode == lhs_pkg::MODE_FAILED);
        end
    end

    assign out_valid  = out_valid_reg;
    assign link_state = link_state_reg;
    assign connected  = connected_reg;
    assign failed     = failed_reg;

    `LHSC_ASSERT_NEXT(a_failed_sticky, state_reg.mode == lhs_pkg::MODE_FAILED, state_reg.mode == lhs_pkg::MODE_FAILED, "failed state was left")
    `LHSC_ASSERT_NEXT(a_idle_exit, state_reg.mode == lhs_pkg::MODE_IDLE, state_reg.mode == lhs_pkg::MODE_IDLE || state_reg.mode == lhs_pkg::MODE_AWAIT, "idle left to a state other than awaiting first")
    `LHSC_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !advance, s1_valid_reg && $stable(state_reg) && $stable(s1_tick_reg) && $stable(s1_update_reg), "held word or state changed while stalled")
    `LHSC_ASSERT_SAME(a_state_idle_only, s1_valid_reg && !advance, !out_valid_reg || out_stall, "input register held without an output stall")

endmodule

`default_nettype wire

FILE: test/link_health_supervisor_core_test.sv
`default_nettype none

module link_health_supervisor_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0] link_state;
        logic       connected;
        logic       failed;
    } status_t;

    class link_scoreboard;
        lhs_pkg::cfg_t regs;
        logic [2:0] mode_now;
        logic [15:0] wait_timer;
        logic [7:0] valid_cnt;
        logic [7:0] missed_cnt;
        logic [7:0] attempt_count;
        status_t    pending_status [$];
        int         mismatches;

        function new();
            regs = '{lhs_pkg::RST_INITIAL_WAIT, lhs_pkg::RST_LOST_WAIT,
                     lhs_pkg::RST_RECONNECT_WAIT, lhs_pkg::RST_UPDATE_WAIT,
                     lhs_pkg::RST_VALID_NEEDED, lhs_pkg::RST_MISSED_ALLOWED,
                     lhs_pkg::RST_RECONNECT_ALLOWED};
            mode_now = lhs_pkg::LINK_IDLE;
            wait_timer = '0;
            valid_cnt = '0;
            missed_cnt = '0;
            attempt_count = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                lhs_pkg::CFG_INITIAL_WAIT:      regs.initial_wait_ms = data;
                lhs_pkg::CFG_LOST_WAIT:         regs.lost_wait_ms = data;
                lhs_pkg::CFG_RECONNECT_WAIT:    regs.reconnect_wait_ms = data;
                lhs_pkg::CFG_UPDATE_WAIT:       regs.update_wait_ms = data;
                lhs_pkg::CFG_VALID_NEEDED:      regs.valid_needed = data[7:0];
                lhs_pkg::CFG_MISSED_ALLOWED:    regs.missed_allowed = data[7:0];
                lhs_pkg::CFG_RECONNECT_ALLOWED: regs.reconnect_allowed = data[7:0];
                default: ;
            endcase
        endfunction

        function bit wait_expired(logic [15:0] limit);
            if (wait_timer != 16'hFFFF)
                wait_timer++;
            return wait_timer >= limit;
        endfunction

        function void clear_counts();
            wait_timer = '0;
            valid_cnt = '0;
            missed_cnt = '0;
        endfunction

        function void drop_link();
            clear_counts();
            if (attempt_count >= regs.reconnect_allowed)
            begin
                mode_now = lhs_pkg::LINK_FAILED;
            end
            else
            begin
                if (attempt_count != 8'hFF)
                    attempt_count++;
                mode_now = lhs_pkg::LINK_RECONNECT;
            end
        endfunction

        function void note_word(bit start, bit upd, bit tk);
            case (mode_now)
                lhs_pkg::LINK_IDLE:
                    if (start)
                    begin
                        mode_now = lhs_pkg::LINK_AWAIT;
                        clear_counts();
                        attempt_count = '0;
                    end
                lhs_pkg::LINK_AWAIT, lhs_pkg::LINK_RECONNECT:
                    if (upd)
                    begin
                        mode_now = lhs_pkg::LINK_CONFIRM;
                        clear_counts();
                    end
                    else if (tk)
                    begin
                        if (wait_expired(mode_now == lhs_pkg::LINK_AWAIT
                                         ? regs.initial_wait_ms
                                         : regs.reconnect_wait_ms))
                        begin
                            mode_now = lhs_pkg::LINK_FAILED;
                            wait_timer = '0;
                        end
                    end
                lhs_pkg::LINK_CONFIRM:
                    if (upd)
                    begin
                        wait_timer = '0;
                        if (valid_cnt != 8'hFF)
                            valid_cnt++;
                        if (valid_cnt >= regs.valid_needed)
                        begin
                            mode_now = lhs_pkg::LINK_CONNECTED;
                            valid_cnt = '0;
                            missed_cnt = '0;
                        end
                    end
                    else if (tk)
                    begin
                        if (wait_expired(regs.update_wait_ms))
                        begin
                            wait_timer = '0;
                            valid_cnt = '0;
                            if (missed_cnt != 8'hFF)
                                missed_cnt++;
                            if (missed_cnt >= regs.missed_allowed)
                                drop_link();
                        end
                    end
                lhs_pkg::LINK_CONNECTED:
                    if (upd)
                        wait_timer = '0;
                    else if (tk)
                    begin
                        if (wait_expired(regs.lost_wait_ms))
                            drop_link();
                    end
                default:
                    mode_now = lhs_pkg::LINK_FAILED;
            endcase
            pending_status.push_back('{mode_now, mode_now == lhs_pkg::LINK_CONNECTED,
                                       mode_now == lhs_pkg::LINK_FAILED});
        endfunction

        function void check_word(status_t got);
            status_t want;
            if (pending_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: link_state %0d connected %0d failed %0d",
                             got.link_state, got.connected, got.failed);
                return;
            end
            want = pending_status.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t exp/act link_state %0d/%0d connected %0d/%0d failed %0d/%0d",
                             $realtime, want.link_state, got.link_state, want.connected,
                             got.connected, want.failed, got.failed);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        start_req = 1'b0;
    logic        status_update = 1'b0;
    logic        tick = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  link_state;
    logic        connected;
    logic        failed;

    link_scoreboard board;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int silence_left = 0;
    int cycles = 0;
    logic [2:0] directed_words [24];

    link_health_supervisor_core dut (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("link_health_supervisor_core_test: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_word('{link_state, connected, failed});
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_word(input bit s, input bit u, input bit t);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_req <= s;
        status_update <= u;
        tick <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_word(s, u, t);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_regs(input lhs_pkg::cfg_t c);
        logic [15:0] vals [8];
        vals[lhs_pkg::CFG_INITIAL_WAIT] = c.initial_wait_ms;
        vals[lhs_pkg::CFG_LOST_WAIT] = c.lost_wait_ms;
        vals[lhs_pkg::CFG_RECONNECT_WAIT] = c.reconnect_wait_ms;
        vals[lhs_pkg::CFG_UPDATE_WAIT] = c.update_wait_ms;
        vals[lhs_pkg::CFG_VALID_NEEDED] = {8'($urandom), c.valid_needed};
        vals[lhs_pkg::CFG_MISSED_ALLOWED] = {8'($urandom), c.missed_allowed};
        vals[lhs_pkg::CFG_RECONNECT_ALLOWED] = {8'($urandom), c.reconnect_allowed};
        vals[CFG_UNUSED] = 16'($urandom);
        for (int i = 0; i < 8; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            board.set_reg(3'(i), vals[i]);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase(input lhs_pkg::cfg_t c, input int idle, input int stall,
                             input int count, input int upd_pct, input int tick_pct,
                             input bit hold);
        bit s;
        bit u;
        bit t;
        drain();
        set_regs(c);
        idle_pct = idle;
        stall_pct = stall;
        if (hold)
            hold_requests <= hold_requests + 1;
        repeat (count)
        begin
            if (silence_left > 0)
            begin
                silence_left--;
                s = ($urandom_range(99) < 5);
                u = 1'b0;
                t = ($urandom_range(99) < 70);
            end
            else
            begin
                if ($urandom_range(99) < 3)
                    silence_left = $urandom_range(1, 40);
                s = ($urandom_range(99) < 5);
                u = ($urandom_range(99) < upd_pct);
                t = ($urandom_range(99) < tick_pct);
            end
            send_word(s, u, t);
        end
    endtask

    initial
    begin
        lhs_pkg::cfg_t last_cfg;
        int   allowed;
        board = new();
        directed_words = '{3'b011, 3'b001, 3'b111, 3'b101, 3'b001, 3'b011, 3'b001, 3'b001,
                           3'b010, 3'b001, 3'b001, 3'b001, 3'b011, 3'b010, 3'b011, 3'b001,
                           3'b011, 3'b001, 3'b001, 3'b000, 3'b110, 3'b010, 3'b010, 3'b000};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_regs('{16'd3, 16'd2, 16'd3, 16'd2, 8'd2, 8'd2, 8'd255});
        foreach (directed_words[i])
            send_word(directed_words[i][2], directed_words[i][1], directed_words[i][0]);

        run_phase('{16'd40, 16'd12, 16'd80, 16'd4, 8'd3, 8'd3, 8'd255}, 0, 0, 350, 35, 50, 0);
        run_phase('{16'd65535, 16'd1, 16'd65535, 16'd65535, 8'd1, 8'd255, 8'd255},
                  80, 0, 250, 30, 10, 0);
        run_phase('{16'd1, 16'd25, 16'd100, 16'd8, 8'd6, 8'd1, 8'd255}, 0, 80, 350, 45, 40, 1);
        run_phase('{16'd65535, 16'd65535, 16'd65535, 16'd65535, 8'd255, 8'd255, 8'd255},
                  38, 38, 400, 70, 60, 1);
        run_phase('{16'd20, 16'd6, 16'd60, 16'd2, 8'd2, 8'd1, 8'd255}, 0, 0, 300, 50, 40, 0);

        drain();
        allowed = board.attempt_count + 1;
        if (allowed > 255 || $urandom_range(1) == 0)
            allowed = 0;
        last_cfg = '{16'($urandom_range(1, 65535)), 16'd3, 16'($urandom_range(1, 3)), 16'd1,
                     8'd1, 8'd1, 8'(allowed)};
        run_phase(last_cfg, 38, 38, 100, 30, 60, 0);

        drain();
        repeat (8) @(posedge clk);
        if (board.mismatches == 0 && board.pending_status.size() == 0)
            $display("link_health_supervisor_core_test: clean");
        else
            $display("link_health_supervisor_core_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
